>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, off while rst_ni is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

>>> sv/lhe_pkg.sv
// types and constants of the landmark heuristic evaluator
`timescale 1ns / 1ps
`default_nettype none

package lhe_pkg;

  localparam int unsigned NODE_W     = 12;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned EST_W      = 33;
  localparam int unsigned LMI_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned OCT_W      = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam int unsigned ROOT2_Q8  = 362;
  localparam int unsigned ONE_SHIFT = 8;
  localparam int unsigned GRID_STEP = 4;
  localparam int unsigned GRID_W    = $clog2(GRID_STEP);

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOADED = 2'd2;

  typedef enum logic [1:0] {
    MODE_IGNORE = 2'd0,
    MODE_RANDOM = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_GRID   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_OCTILE = 3'd1,
    OP_ZERO   = 3'd2,
    OP_SWEEP  = 3'd3,
    OP_SINGLE = 3'd4
  } op_e;

  typedef struct packed {
    mode_e            mode;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] loaded;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [CNT_W-1:0]  lm;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              zero_a;
    logic              zero_b;
    logic [DIST_W-1:0] dist_val;
    logic [EST_W-1:0]  base;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  rsum;
  } entry_t;

  typedef struct packed {
    logic res_load;
    logic pipe_busy;
  } back_stat_t;

endpackage

`default_nettype wire

>>> sv/lhe_ram.sv
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module lhe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> sv/lhe_front.sv
// front end: accepts items, computes octile distance, classifies work
`timescale 1ns / 1ps
`default_nettype none

module lhe_front #(
  parameter int unsigned MAX_LANDMARKS = 16,
  parameter int unsigned NODE_COUNT    = 4096,
  parameter int unsigned MAP_SIZE      = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire lhe_pkg::cfg_t                      cfg_i,
  input  wire logic                               push_i,
  output logic                                    full_o,
  input  wire logic                               kind_i,
  input  wire logic [lhe_pkg::LMI_W-1:0]          landmark_index_i,
  input  wire logic [lhe_pkg::NODE_W-1:0]         node_a_i,
  input  wire logic [lhe_pkg::NODE_W-1:0]         node_b_i,
  input  wire logic signed [lhe_pkg::DIST_W-1:0]  distance_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]        x_a_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]        y_a_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]        x_b_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]        y_b_i,
  output logic                                    q_push_o,
  output lhe_pkg::entry_t                         q_entry_o,
  input  wire logic                               q_ready_i
);

  localparam int unsigned CW  = lhe_pkg::COORD_W;
  localparam int unsigned NW  = lhe_pkg::NODE_W;
  localparam int unsigned CNW = lhe_pkg::CNT_W;
  localparam int unsigned SW  = lhe_pkg::SUM_W;
  localparam int unsigned OW  = lhe_pkg::OCT_W;
  localparam int unsigned EW  = lhe_pkg::EST_W;
  localparam int unsigned GW  = lhe_pkg::GRID_W;
  localparam logic [CW-1:0] COORD_MAX = CW'(MAP_SIZE - 1);

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] v);
    logic [CW-1:0] c;
    c = v;
    if (32'(v) >= MAP_SIZE) begin
      c = COORD_MAX;
    end
    return c;
  endfunction

  logic                     s1_v_q;
  logic                     s1_kind_q;
  logic [lhe_pkg::LMI_W-1:0] s1_lmi_q;
  logic [NW-1:0]            s1_na_q, s1_nb_q;
  logic                     s1_za_q, s1_zb_q;
  logic [lhe_pkg::DIST_W-1:0] s1_dist_q;
  logic [CW-1:0]            s1_x1_q, s1_y1_q, s1_x2_q, s1_y2_q;
  logic [CW-1:0]            s1_dx_q, s1_dy_q;

  logic          s1_ready, accept, load_ok, keep, za, zb;
  logic [CW-1:0] x1, y1, x2, y2, dx, dy;

  assign s1_ready = !s1_v_q || q_ready_i;
  assign full_o   = !s1_ready;
  assign accept   = push_i && s1_ready;

  assign load_ok = (32'(landmark_index_i) < MAX_LANDMARKS) && (32'(node_a_i) < NODE_COUNT);
  assign keep    = (kind_i == lhe_pkg::KIND_QUERY) || load_ok;
  assign za      = 32'(node_a_i) >= NODE_COUNT;
  assign zb      = 32'(node_b_i) >= NODE_COUNT;

  assign x1 = clamp_coord(x_a_i);
  assign y1 = clamp_coord(y_a_i);
  assign x2 = clamp_coord(x_b_i);
  assign y2 = clamp_coord(y_b_i);
  assign dx = (x1 > x2) ? x1 - x2 : x2 - x1;
  assign dy = (y1 > y2) ? y1 - y2 : y2 - y1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind_i;
      s1_lmi_q  <= landmark_index_i;
      s1_na_q   <= za ? '0 : node_a_i;
      s1_nb_q   <= zb ? '0 : node_b_i;
      s1_za_q   <= za;
      s1_zb_q   <= zb;
      s1_dist_q <= distance_i;
      s1_x1_q   <= x1;
      s1_y1_q   <= y1;
      s1_x2_q   <= x2;
      s1_y2_q   <= y2;
      s1_dx_q   <= dx;
      s1_dy_q   <= dy;
    end
  end

  logic [CW-1:0]  lo, hi;
  logic [OW-1:0]  oct;
  logic [CNW-1:0] loaded_c, limit;
  logic [CW:0]    xs, ys;
  logic           grid_ok;

  assign lo  = (s1_dx_q < s1_dy_q) ? s1_dx_q : s1_dy_q;
  assign hi  = (s1_dx_q < s1_dy_q) ? s1_dy_q : s1_dx_q;
  assign oct = OW'(lo) * OW'(lhe_pkg::ROOT2_Q8) + (OW'(hi - lo) << lhe_pkg::ONE_SHIFT);

  assign loaded_c = (32'(cfg_i.loaded) > MAX_LANDMARKS) ? CNW'(MAX_LANDMARKS) : cfg_i.loaded;
  assign limit    = (cfg_i.used < loaded_c) ? cfg_i.used : loaded_c;

  assign xs      = {1'b0, s1_x1_q} + {1'b0, s1_x2_q};
  assign ys      = {1'b0, s1_y1_q} + {1'b0, s1_y2_q};
  assign grid_ok = (xs[GW-1:0] == '0) && (ys[GW-1:0] == '0);

  always_comb begin
    q_entry_o          = '0;
    q_entry_o.lm       = CNW'(s1_lmi_q);
    q_entry_o.node_a   = s1_na_q;
    q_entry_o.node_b   = s1_nb_q;
    q_entry_o.zero_a   = s1_za_q;
    q_entry_o.zero_b   = s1_zb_q;
    q_entry_o.dist_val = s1_dist_q;
    q_entry_o.base     = EW'(oct);
    q_entry_o.rsum     = SW'(xs) + SW'(ys);
    q_entry_o.op       = lhe_pkg::OP_OCTILE;
    if (s1_kind_q == lhe_pkg::KIND_LOAD) begin
      q_entry_o.op = lhe_pkg::OP_LOAD;
    end else begin
      unique case (cfg_i.mode)
        lhe_pkg::MODE_IGNORE: q_entry_o.op = lhe_pkg::OP_OCTILE;
        lhe_pkg::MODE_RANDOM: begin
          if (loaded_c != '0) begin
            q_entry_o.op    = lhe_pkg::OP_SINGLE;
            q_entry_o.count = loaded_c;
          end
        end
        lhe_pkg::MODE_MAX: begin
          if (limit != '0) begin
            q_entry_o.op    = lhe_pkg::OP_SWEEP;
            q_entry_o.count = limit;
          end
        end
        lhe_pkg::MODE_GRID: begin
          if (!grid_ok) begin
            q_entry_o.op   = lhe_pkg::OP_ZERO;
            q_entry_o.base = '0;
          end else if (loaded_c != '0) begin
            q_entry_o.op    = lhe_pkg::OP_SWEEP;
            q_entry_o.count = loaded_c;
          end
        end
        default: q_entry_o.op = lhe_pkg::OP_OCTILE;
      endcase
    end
  end

  assign q_push_o = s1_v_q;

endmodule

`default_nettype wire

>>> sv/lhe_queue.sv
// short queue of classified work between front and back
`timescale 1ns / 1ps
`default_nettype none

module lhe_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lhe_pkg::entry_t entry_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output lhe_pkg::entry_t      entry_o,
  input  wire logic            pop_i
);

  localparam int unsigned DEPTH = lhe_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CTW   = $clog2(DEPTH + 1);

  lhe_pkg::entry_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CTW-1:0]  cnt_q;
  logic            do_push, do_pop;

  assign ready_o = cnt_q != CTW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/lhe_back.sv
// back end: table writes, modulo for random mode, landmark sweep and result register
`timescale 1ns / 1ps
`default_nettype none

module lhe_back #(
  parameter int unsigned MAX_LANDMARKS = 16,
  parameter int unsigned NODE_COUNT    = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  input  wire lhe_pkg::entry_t           q_entry_i,
  output logic                           q_pop_o,
  input  wire logic                      res_pop_i,
  output logic                           res_empty_o,
  output logic [lhe_pkg::EST_W-1:0]      estimate_o,
  output lhe_pkg::back_stat_t            stat_o
);

  localparam int unsigned DEPTH = MAX_LANDMARKS * NODE_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = lhe_pkg::DIST_W;
  localparam int unsigned EW    = lhe_pkg::EST_W;
  localparam int unsigned CNW   = lhe_pkg::CNT_W;
  localparam int unsigned NW    = lhe_pkg::NODE_W;
  localparam int unsigned SW    = lhe_pkg::SUM_W;
  localparam int unsigned REMW  = SW + CNW;
  localparam int unsigned STW   = $clog2(SW);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DRAIN = 4'b1000
  } back_state_e;

  back_state_e    state_q, state_d;
  logic [CNW-1:0] lm_q, lm_d, left_q, left_d, div_q, div_d;
  logic [NW-1:0]  na_q, na_d, nb_q, nb_d;
  logic           za_q, za_d, zb_q, zb_d;
  logic [EW-1:0]  max_q, max_d, abs_q, abs_d, out_q;
  logic [SW-1:0]  r_q, r_d;
  logic [STW-1:0] step_q, step_d;
  logic           rd_v_q, ad_v_q, out_v_q;

  logic           we, re, res_load;
  logic [AW-1:0]  waddr, raddr_a, raddr_b;
  logic [DW-1:0]  rdata_a, rdata_b, ent_a, ent_b;
  logic [EW-1:0]  diff_ab, diff_ba;
  logic [REMW-1:0] rem_shift;
  logic           rem_ge;
  logic [SW-1:0]  rem_next;

  assign waddr   = AW'(q_entry_i.lm) * AW'(NODE_COUNT) + AW'(q_entry_i.node_a);
  assign raddr_a = AW'(lm_q) * AW'(NODE_COUNT) + AW'(na_q);
  assign raddr_b = AW'(lm_q) * AW'(NODE_COUNT) + AW'(nb_q);

  lhe_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (q_entry_i.dist_val),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // signed difference both ways, keep the non-negative one
  assign ent_a   = za_q ? '0 : rdata_a;
  assign ent_b   = zb_q ? '0 : rdata_b;
  assign diff_ab = {ent_a[DW-1], ent_a} - {ent_b[DW-1], ent_b};
  assign diff_ba = {ent_b[DW-1], ent_b} - {ent_a[DW-1], ent_a};
  assign abs_d   = diff_ab[EW-1] ? diff_ba : diff_ab;

  // one restoring step of the modulo per cycle
  assign rem_shift = REMW'(div_q) << step_q;
  assign rem_ge    = REMW'(r_q) >= rem_shift;
  assign rem_next  = rem_ge ? SW'(REMW'(r_q) - rem_shift) : r_q;

  always_comb begin
    state_d  = state_q;
    lm_d     = lm_q;
    left_d   = left_q;
    div_d    = div_q;
    na_d     = na_q;
    nb_d     = nb_q;
    za_d     = za_q;
    zb_d     = zb_q;
    max_d    = max_q;
    r_d      = r_q;
    step_d   = step_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          na_d    = q_entry_i.node_a;
          nb_d    = q_entry_i.node_b;
          za_d    = q_entry_i.zero_a;
          zb_d    = q_entry_i.zero_b;
          max_d   = q_entry_i.base;
          unique case (q_entry_i.op) inside
            lhe_pkg::OP_LOAD: we = 1'b1;
            lhe_pkg::OP_OCTILE, lhe_pkg::OP_ZERO: state_d = S_DRAIN;
            lhe_pkg::OP_SWEEP: begin
              lm_d    = '0;
              left_d  = q_entry_i.count;
              state_d = S_SWEEP;
            end
            lhe_pkg::OP_SINGLE: begin
              r_d     = q_entry_i.rsum;
              div_d   = q_entry_i.count;
              step_d  = STW'(SW - 1);
              state_d = S_MOD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        r_d = rem_next;
        if (step_q == '0) begin
          lm_d    = CNW'(rem_next);
          left_d  = CNW'(1);
          state_d = S_SWEEP;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_SWEEP: begin
        re     = 1'b1;
        lm_d   = lm_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == CNW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !ad_v_q && (!out_v_q || res_pop_i)) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (ad_v_q && (abs_q > max_q)) begin
      max_d = abs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_v_q  <= 1'b0;
      ad_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= re;
      ad_v_q  <= rd_v_q;
      if (res_load) begin
        out_v_q <= 1'b1;
      end else if (res_pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lm_q   <= lm_d;
    left_q <= left_d;
    div_q  <= div_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    za_q   <= za_d;
    zb_q   <= zb_d;
    max_q  <= max_d;
    r_q    <= r_d;
    step_q <= step_d;
    abs_q  <= abs_d;
    if (res_load) begin
      out_q <= max_q;
    end
  end

  assign res_empty_o      = !out_v_q;
  assign estimate_o       = out_q;
  assign stat_o.res_load  = res_load;
  assign stat_o.pipe_busy = rd_v_q || ad_v_q;

endmodule

`default_nettype wire

>>> sv/landmark_heuristic_evaluator_top.sv
// top level of the landmark heuristic evaluator
//
//   channel   handshake              payload
//   input     push / full            kind, landmark_index, node_a, node_b, distance, coords
//   result    empty / pop            estimate
//   config    cfg_we_i               cfg_index_i, cfg_data_i
//
// a load item passes the front-end register and the queue before the table write
// and the back end takes it without leaving its idle state
// a query does one two-port table read per landmark; random mode first runs the bit-serial modulo unit
// the front end takes a new item every cycle while the queue has room
// no clearing pass after reset: the user must write table entries before reading them; not enforced here
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module landmark_heuristic_evaluator_top #(
  parameter int unsigned MAX_LANDMARKS = 16,
  parameter int unsigned NODE_COUNT    = 4096,
  parameter int unsigned MAP_SIZE      = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                kind_i,
  input  wire logic [lhe_pkg::LMI_W-1:0]           landmark_index_i,
  input  wire logic [lhe_pkg::NODE_W-1:0]          node_a_i,
  input  wire logic [lhe_pkg::NODE_W-1:0]          node_b_i,
  input  wire logic signed [lhe_pkg::DIST_W-1:0]   distance_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]         x_a_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]         y_a_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]         x_b_i,
  input  wire logic [lhe_pkg::COORD_W-1:0]         y_b_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [lhe_pkg::EST_W-1:0]                estimate_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lhe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [lhe_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned CNW = lhe_pkg::CNT_W;

  lhe_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lhe_pkg::REG_MODE:   cfg_d.mode   = lhe_pkg::mode_e'(cfg_data_i[1:0]);
        lhe_pkg::REG_USED:   cfg_d.used   = cfg_data_i[CNW-1:0];
        lhe_pkg::REG_LOADED: cfg_d.loaded = cfg_data_i[CNW-1:0];
        default:             cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= lhe_pkg::MODE_MAX;
      cfg_q.used   <= CNW'(16);
      cfg_q.loaded <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                q_push, q_ready, q_valid, q_pop;
  lhe_pkg::entry_t     q_in, q_out;
  lhe_pkg::back_stat_t stat;

  lhe_front #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .NODE_COUNT    (NODE_COUNT),
    .MAP_SIZE      (MAP_SIZE)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .push_i           (push),
    .full_o           (full),
    .kind_i           (kind_i),
    .landmark_index_i (landmark_index_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .distance_i       (distance_i),
    .x_a_i            (x_a_i),
    .y_a_i            (y_a_i),
    .x_b_i            (x_b_i),
    .y_b_i            (y_b_i),
    .q_push_o         (q_push),
    .q_entry_o        (q_in),
    .q_ready_i        (q_ready)
  );

  lhe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  lhe_back #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .NODE_COUNT    (NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .estimate_o  (estimate_o),
    .stat_o      (stat)
  );

  // a waiting result is never overwritten
  `ASSERT_CLK(a_no_overwrite, (stat.res_load && !empty) |-> pop, "result overwritten")
  // the result is taken only once all table reads are folded in
  `ASSERT_NEVER(a_load_drained, stat.res_load && stat.pipe_busy, "result loaded early")
  // a result shows up only after the back end loads it
  `ASSERT_CLK(a_fill_by_load, $fell(empty) |-> $past(stat.res_load), "result without load")

endmodule

`default_nettype wire
